// ===== rtl/prqs_pkg.sv =====
// shared constants, types and sine table for the point rotation unit
`default_nettype none

package prqs_pkg;

  // coordinate and register widths
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 19;
  localparam int CFG_IDX_W = 2;

  // quarter-wave table
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = IDX_W + 2;
  localparam int ROM_W = 16;
  localparam int TRIG_W = ROM_W + 1;

  // angle / 352 = (angle >> 5) / 11, the /11 done as multiply by 11916 >> 17
  // (exact for every 14 bit quotient input)
  localparam int ANGLE_PRE_SHIFT = 5;
  localparam int ANGLE_Q_W = ANGLE_W - ANGLE_PRE_SHIFT;
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_PROD_W = 2 * ANGLE_Q_W;
  localparam logic [ANGLE_Q_W-1:0] RECIP_11 = ANGLE_Q_W'(11916);

  // arithmetic widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + TRIG_W;
  localparam int FRAC_W = 16;
  localparam int ACC_W = PROD_W + 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ANGLE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quadrant_t;

  // first quarter of a sine period, unsigned q16
  localparam logic [ROM_W-1:0] SINE_ROM [TABLE_DEPTH] = '{
    16'h0000, 16'h0192, 16'h0324, 16'h04b6, 16'h0648, 16'h07da, 16'h096c, 16'h0afe,
    16'h0c90, 16'h0e21, 16'h0fb3, 16'h1144, 16'h12d5, 16'h1466, 16'h15f7, 16'h1787,
    16'h1918, 16'h1aa8, 16'h1c37, 16'h1dc7, 16'h1f56, 16'h20e5, 16'h2274, 16'h2402,
    16'h2590, 16'h271e, 16'h28ab, 16'h2a38, 16'h2bc4, 16'h2d50, 16'h2edc, 16'h3067,
    16'h31f1, 16'h337b, 16'h3505, 16'h368e, 16'h3817, 16'h399f, 16'h3b26, 16'h3cad,
    16'h3e34, 16'h3fb9, 16'h413f, 16'h42c3, 16'h4447, 16'h45ca, 16'h474d, 16'h48cf,
    16'h4a50, 16'h4bd0, 16'h4d50, 16'h4ecf, 16'h504d, 16'h51cb, 16'h5347, 16'h54c3,
    16'h563e, 16'h57b8, 16'h5932, 16'h5aaa, 16'h5c22, 16'h5d98, 16'h5f0e, 16'h6083,
    16'h61f7, 16'h636a, 16'h64dc, 16'h664d, 16'h67bd, 16'h692d, 16'h6a9b, 16'h6c08,
    16'h6d74, 16'h6edf, 16'h7049, 16'h71b2, 16'h7319, 16'h7480, 16'h75e5, 16'h774a,
    16'h78ad, 16'h7a0f, 16'h7b70, 16'h7cd0, 16'h7e2e, 16'h7f8b, 16'h80e7, 16'h8242,
    16'h839c, 16'h84f4, 16'h864b, 16'h87a1, 16'h88f5, 16'h8a48, 16'h8b9a, 16'h8cea,
    16'h8e39, 16'h8f87, 16'h90d3, 16'h921e, 16'h9368, 16'h94b0, 16'h95f6, 16'h973b,
    16'h987f, 16'h99c1, 16'h9b02, 16'h9c41, 16'h9d7f, 16'h9ebb, 16'h9ff6, 16'ha12f,
    16'ha267, 16'ha39d, 16'ha4d1, 16'ha604, 16'ha736, 16'ha865, 16'ha993, 16'haac0,
    16'habeb, 16'had14, 16'hae3b, 16'haf61, 16'hb085, 16'hb1a7, 16'hb2c8, 16'hb3e7,
    16'hb504, 16'hb620, 16'hb739, 16'hb851, 16'hb968, 16'hba7c, 16'hbb8e, 16'hbc9f,
    16'hbdae, 16'hbebb, 16'hbfc7, 16'hc0d0, 16'hc1d8, 16'hc2dd, 16'hc3e1, 16'hc4e3,
    16'hc5e3, 16'hc6e1, 16'hc7de, 16'hc8d8, 16'hc9d0, 16'hcac7, 16'hcbbb, 16'hccae,
    16'hcd9e, 16'hce8d, 16'hcf79, 16'hd064, 16'hd14c, 16'hd233, 16'hd317, 16'hd3fa,
    16'hd4da, 16'hd5b9, 16'hd695, 16'hd76f, 16'hd847, 16'hd91e, 16'hd9f2, 16'hdac3,
    16'hdb93, 16'hdc61, 16'hdd2c, 16'hddf6, 16'hdebd, 16'hdf82, 16'he045, 16'he106,
    16'he1c5, 16'he281, 16'he33b, 16'he3f4, 16'he4a9, 16'he55d, 16'he60f, 16'he6be,
    16'he76b, 16'he816, 16'he8be, 16'he965, 16'hea09, 16'heaab, 16'heb4a, 16'hebe7,
    16'hec82, 16'hed1b, 16'hedb2, 16'hee46, 16'heed8, 16'hef67, 16'heff5, 16'hf07f,
    16'hf108, 16'hf18e, 16'hf212, 16'hf294, 16'hf313, 16'hf390, 16'hf40b, 16'hf483,
    16'hf4f9, 16'hf56d, 16'hf5de, 16'hf64d, 16'hf6b9, 16'hf723, 16'hf78b, 16'hf7f0,
    16'hf853, 16'hf8b4, 16'hf912, 16'hf96d, 16'hf9c7, 16'hfa1e, 16'hfa72, 16'hfac4,
    16'hfb14, 16'hfb61, 16'hfbac, 16'hfbf4, 16'hfc3a, 16'hfc7e, 16'hfcbf, 16'hfcfd,
    16'hfd3a, 16'hfd73, 16'hfdab, 16'hfde0, 16'hfe12, 16'hfe42, 16'hfe70, 16'hfe9b,
    16'hfec3, 16'hfeea, 16'hff0d, 16'hff2f, 16'hff4d, 16'hff6a, 16'hff84, 16'hff9b,
    16'hffb0, 16'hffc3, 16'hffd3, 16'hffe0, 16'hffeb, 16'hfff4, 16'hfffa, 16'hfffe
  };

endpackage

`default_nettype wire

// ===== rtl/point_rotation_quarter_sine_unit.sv =====
// point rotation about a configured origin using a quarter-wave sine table
//
// usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes origin_x (0),
//   origin_y (1) and angle_millideg (2); other indexes are dropped. cfg_ready
//   is always high. write registers only while no point is in flight.
//   in channel (in_valid/in_ready) takes one point beat per in_ready cycle:
//   point_x, point_y, last_point. out channel (out_valid/out_ready) gives one
//   result beat per point, in order: rot_x, rot_y, clip_x, clip_y, last_out.
//   path: each input beat reaches out_valid through four register
//   stages (phase divide, sine lookup, multiply, sum and saturate).
//   throughput: one point per clock while out_ready is high; fully pipelined.
//   stall: each stage holds while the stage after it is full and stalled,
//   so bubbles are squeezed out and input stays open until every stage is
//   full. nothing is dropped or repeated.
//   reset: pipeline valids cleared, origin and angle return to zero.
`default_nettype none

module point_rotation_quarter_sine_unit (
  input  wire                                 clk,
  input  wire                                 rst,
  // configuration
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [prqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [prqs_pkg::ANGLE_W-1:0]        cfg_data,
  // points in
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [prqs_pkg::COORD_W-1:0]        point_x,
  input  wire  [prqs_pkg::COORD_W-1:0]        point_y,
  input  wire                                 last_point,
  // results out
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [prqs_pkg::COORD_W-1:0]        rot_x,
  output logic [prqs_pkg::COORD_W-1:0]        rot_y,
  output logic                                clip_x,
  output logic                                clip_y,
  output logic                                last_out
);

  import prqs_pkg::*;

  // configuration registers
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [ANGLE_W-1:0] angle_millideg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      angle_millideg <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: origin_x <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y: origin_y <= cfg_data[COORD_W-1:0];
        REG_ANGLE:    angle_millideg <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // a stage loads when it is empty or its contents move on this cycle
  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: coordinate differences and phase = angle / 352
  logic [ANGLE_Q_W-1:0]      angle_q;
  logic [RECIP_PROD_W-1:0]   recip_prod;
  logic signed [DIFF_W-1:0]  dx_in;
  logic signed [DIFF_W-1:0]  dy_in;

  assign angle_q    = angle_millideg[ANGLE_W-1:ANGLE_PRE_SHIFT];
  assign recip_prod = angle_q * RECIP_11;
  assign dx_in = $signed({1'b0, point_x}) - $signed({1'b0, origin_x});
  assign dy_in = $signed({1'b0, point_y}) - $signed({1'b0, origin_y});

  logic [PHASE_W-1:0]        s1_phase;
  logic signed [DIFF_W-1:0]  s1_dx;
  logic signed [DIFF_W-1:0]  s1_dy;
  logic [COORD_W-1:0]        s1_ox;
  logic [COORD_W-1:0]        s1_oy;
  logic                      s1_last;

  always_ff @(posedge clk) begin
    if (en1) begin
      // phase wraps modulo one turn by keeping the low bits
      s1_phase <= recip_prod[RECIP_SHIFT +: PHASE_W];
      s1_dx    <= dx_in;
      s1_dy    <= dy_in;
      s1_ox    <= origin_x;
      s1_oy    <= origin_y;
      s1_last  <= last_point;
    end
  end

  // stage 2: table lookup with quadrant mirroring and negation
  logic [IDX_W-1:0]          tbl_idx;
  logic [ROM_W-1:0]          direct;
  logic [ROM_W-1:0]          mirror;
  logic signed [TRIG_W-1:0]  direct_s;
  logic signed [TRIG_W-1:0]  mirror_s;
  logic signed [TRIG_W-1:0]  sin_val;
  logic signed [TRIG_W-1:0]  cos_val;

  assign tbl_idx  = s1_phase[IDX_W-1:0];
  assign direct   = SINE_ROM[tbl_idx];
  // depth - 1 - index is the bitwise complement for a power-of-two depth
  assign mirror   = SINE_ROM[~tbl_idx];
  assign direct_s = $signed({1'b0, direct});
  assign mirror_s = $signed({1'b0, mirror});

  always_comb begin
    case (quadrant_t'(s1_phase[PHASE_W-1:IDX_W]))
      QUAD_0: begin
        sin_val = direct_s;
        cos_val = mirror_s;
      end
      QUAD_1: begin
        sin_val = mirror_s;
        cos_val = -direct_s;
      end
      QUAD_2: begin
        sin_val = -direct_s;
        cos_val = -mirror_s;
      end
      default: begin
        sin_val = -mirror_s;
        cos_val = direct_s;
      end
    endcase
  end

  logic signed [TRIG_W-1:0]  s2_sin;
  logic signed [TRIG_W-1:0]  s2_cos;
  logic signed [DIFF_W-1:0]  s2_dx;
  logic signed [DIFF_W-1:0]  s2_dy;
  logic [COORD_W-1:0]        s2_ox;
  logic [COORD_W-1:0]        s2_oy;
  logic                      s2_last;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sin  <= sin_val;
      s2_cos  <= cos_val;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_ox   <= s1_ox;
      s2_oy   <= s1_oy;
      s2_last <= s1_last;
    end
  end

  // stage 3: four signed 17x17 products
  logic signed [PROD_W-1:0]  s3_dx_cos;
  logic signed [PROD_W-1:0]  s3_dy_sin;
  logic signed [PROD_W-1:0]  s3_dx_sin;
  logic signed [PROD_W-1:0]  s3_dy_cos;
  logic [COORD_W-1:0]        s3_ox;
  logic [COORD_W-1:0]        s3_oy;
  logic                      s3_last;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_dx_cos <= s2_dx * s2_cos;
      s3_dy_sin <= s2_dy * s2_sin;
      s3_dx_sin <= s2_dx * s2_sin;
      s3_dy_cos <= s2_dy * s2_cos;
      s3_ox     <= s2_ox;
      s3_oy     <= s2_oy;
      s3_last   <= s2_last;
    end
  end

  // stage 4: q16 sums, floor and saturate into the output register
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;
  logic [ACC_W-FRAC_W-1:0]   whole_x;
  logic [ACC_W-FRAC_W-1:0]   whole_y;
  logic [COORD_W-1:0]        sat_x;
  logic [COORD_W-1:0]        sat_y;
  logic                      clp_x;
  logic                      clp_y;

  assign acc_x = $signed({{(ACC_W-COORD_W-FRAC_W){1'b0}}, s3_ox, {FRAC_W{1'b0}}})
               + ACC_W'(s3_dx_cos) - ACC_W'(s3_dy_sin);
  assign acc_y = $signed({{(ACC_W-COORD_W-FRAC_W){1'b0}}, s3_oy, {FRAC_W{1'b0}}})
               + ACC_W'(s3_dx_sin) + ACC_W'(s3_dy_cos);
  assign whole_x = acc_x[ACC_W-1:FRAC_W];
  assign whole_y = acc_y[ACC_W-1:FRAC_W];

  always_comb begin
    if (acc_x < 0) begin
      sat_x = '0;
      clp_x = 1'b1;
    end else if (|whole_x[ACC_W-FRAC_W-1:COORD_W]) begin
      sat_x = '1;
      clp_x = 1'b1;
    end else begin
      sat_x = whole_x[COORD_W-1:0];
      clp_x = 1'b0;
    end
    if (acc_y < 0) begin
      sat_y = '0;
      clp_y = 1'b1;
    end else if (|whole_y[ACC_W-FRAC_W-1:COORD_W]) begin
      sat_y = '1;
      clp_y = 1'b1;
    end else begin
      sat_y = whole_y[COORD_W-1:0];
      clp_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      rot_x    <= sat_x;
      rot_y    <= sat_y;
      clip_x   <= clp_x;
      clip_y   <= clp_y;
      last_out <= s3_last;
    end
  end

  assign out_valid = v4;

  // a saturated coordinate sits at one of the two range ends
  a_clip_x_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && clip_x |-> rot_x == '0 || rot_x == '1)
    else $error("clip_x set with an unsaturated rot_x");

  // input only closes when every stage holds a point
  a_full_when_closed: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && v3 && v4)
    else $error("input stalled while the pipeline has a bubble");

  // a held multiply stage keeps its point and its dx*cos and dy*cos products
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !en3 |=> v3 && $stable(s3_dx_cos) && $stable(s3_dy_cos))
    else $error("stalled stage 3 lost or changed its point");

endmodule

`default_nettype wire
